### hdl/bdpc_pkg.sv
package bdpc_pkg;

    localparam int unsigned DEBOUNCE_W = 10;
    localparam int unsigned THRESH_W   = 16;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(40);
    localparam logic [THRESH_W-1:0]   SHORT_RESET    = THRESH_W'(100);
    localparam logic [THRESH_W-1:0]   LONG_RESET     = THRESH_W'(2000);
    localparam logic [THRESH_W-1:0]   BLOCKED_RESET  = THRESH_W'(8000);

    typedef enum logic [1:0] {
        PH_WAIT_PRESS     = 2'd0,
        PH_SETTLE_PRESS   = 2'd1,
        PH_WAIT_RELEASE   = 2'd2,
        PH_SETTLE_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_SHORT   = 2'd1,
        CLS_LONG    = 2'd2,
        CLS_BLOCKED = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        EV_SHORT    = 2'd0,
        EV_LONG     = 2'd1,
        EV_BLOCKED  = 2'd2,
        EV_RELEASED = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_SHORT    = 2'd1,
        REG_LONG     = 2'd2,
        REG_BLOCKED  = 2'd3
    } reg_idx_t;

    function automatic class_t classify(
        input logic [HOLD_W-1:0]   hold,
        input logic [THRESH_W-1:0] short_min,
        input logic [THRESH_W-1:0] long_min,
        input logic [THRESH_W-1:0] blocked_min
    );
        class_t cls;
        cls = CLS_NONE;
        if (hold >= short_min && hold < long_min)
        begin
            cls = CLS_SHORT;
        end
        else if (hold >= long_min && hold < blocked_min)
        begin
            cls = CLS_LONG;
        end
        else if (hold >= blocked_min)
        begin
            cls = CLS_BLOCKED;
        end
        return cls;
    endfunction

endpackage

### hdl/button_debounce_press_classifier_top.sv
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    pressed (1 bit)
// out       result     out_valid / out_ready  event_code (2 bit)
// cfg       write      cfg_write              cfg_index (2 bit), cfg_data (16 bit)
//
// One request per cycle sustained while results are taken. A request sits in
// the input register, then updates the debounce state and loads the result
// register once the result slot is free or being taken.
// Reset (rst_n low) clears phase, counters, last class and the thresholds
// to their defaults. A stalled result holds the result register and the
// input register; in_ready drops only while both are full.
module button_debounce_press_classifier_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            pressed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      event_code,
    input  logic                            cfg_write,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdpc_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [THRESH_W-1:0]   short_min_reg;
    logic [THRESH_W-1:0]   long_min_reg;
    logic [THRESH_W-1:0]   blocked_min_reg;

    logic                  s1_valid_reg;
    logic                  pressed_reg;
    logic                  s1_fire;

    phase_t                phase_reg, phase_next;
    logic [DEBOUNCE_W-1:0] settle_reg, settle_next;
    logic [HOLD_W-1:0]     hold_reg, hold_next;
    class_t                class_reg, class_next;
    class_t                cls;

    logic                  emit;
    event_t                code;
    logic                  out_valid_reg;
    event_t                event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RESET;
            short_min_reg   <= SHORT_RESET;
            long_min_reg    <= LONG_RESET;
            blocked_min_reg <= BLOCKED_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DEBOUNCE: debounce_reg    <= cfg_data[DEBOUNCE_W-1:0];
                REG_SHORT:    short_min_reg   <= cfg_data[THRESH_W-1:0];
                REG_LONG:     long_min_reg    <= cfg_data[THRESH_W-1:0];
                REG_BLOCKED:  blocked_min_reg <= cfg_data[THRESH_W-1:0];
                default:      ;
            endcase
        end
    end

    // stage 1 drains whenever the result slot is free or being taken
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pressed_reg <= pressed;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        settle_next = settle_reg;
        hold_next   = '0;
        class_next  = class_reg;
        cls         = CLS_NONE;
        emit        = 1'b0;
        code        = EV_SHORT;

        case (phase_reg)
            PH_WAIT_PRESS:
            begin
                if (pressed_reg)
                begin
                    settle_next = debounce_reg;
                    phase_next  = PH_SETTLE_PRESS;
                end
            end
            PH_SETTLE_PRESS:
            begin
                if (!pressed_reg)
                begin
                    phase_next = PH_WAIT_PRESS;
                end
                else if (settle_reg != '0)
                begin
                    settle_next = settle_reg - 1'b1;
                end
                else
                begin
                    phase_next = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE:
            begin
                if (!pressed_reg)
                begin
                    settle_next = debounce_reg;
                    phase_next  = PH_SETTLE_RELEASE;
                end
            end
            PH_SETTLE_RELEASE:
            begin
                if (pressed_reg)
                begin
                    phase_next = PH_WAIT_RELEASE;
                end
                else if (settle_reg != '0)
                begin
                    settle_next = settle_reg - 1'b1;
                end
                else
                begin
                    phase_next = PH_WAIT_PRESS;
                    if (class_reg == CLS_BLOCKED)
                    begin
                        emit = 1'b1;
                        code = EV_RELEASED;
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT_PRESS;
            end
        endcase

        // hold count is zero outside wait-release, so a bounce restarts it at 1
        if (phase_next == PH_WAIT_RELEASE)
        begin
            hold_next = (hold_reg == '1) ? hold_reg : hold_reg + 1'b1;
            cls = classify(hold_next, short_min_reg, long_min_reg, blocked_min_reg);
            if (cls != class_reg)
            begin
                class_next = cls;
                case (cls)
                    CLS_SHORT:
                    begin
                        emit = 1'b1;
                        code = EV_SHORT;
                    end
                    CLS_LONG:
                    begin
                        emit = 1'b1;
                        code = EV_LONG;
                    end
                    CLS_BLOCKED:
                    begin
                        emit = 1'b1;
                        code = EV_BLOCKED;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT_PRESS;
            settle_reg <= '0;
            hold_reg   <= '0;
            class_reg  <= CLS_NONE;
        end
        else if (s1_fire)
        begin
            phase_reg  <= phase_next;
            settle_reg <= settle_next;
            hold_reg   <= hold_next;
            class_reg  <= class_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            event_reg <= code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

endmodule

### hdl/bdpc_checker.sv
module bdpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] event_code
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code))
        else $error("result changed while stalled");

    // a free or draining result slot never blocks requests
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("request blocked with free result slot");

    // both stages come out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && in_ready)
        else $error("pipeline not empty after reset");

    a_no_spurious_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low without pending result");

    // a waiting request stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request withdrawn before accept");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_code (event_code)
);

### sim/press_event_checker.sv
module press_event_checker
    import bdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  pressed,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            event_code,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    logic [DEBOUNCE_W-1:0] deb_ticks;
    logic [THRESH_W-1:0]   short_min;
    logic [THRESH_W-1:0]   long_min;
    logic [THRESH_W-1:0]   blocked_min;
    phase_t                phase;
    logic [DEBOUNCE_W-1:0] settle;
    logic [HOLD_W-1:0]     hold;
    class_t                last_cls;
    event_t                events_due[$];
    event_t                want;

    // short wins over blocked where both match; long overlaps neither of them
    function automatic class_t grade_hold(input logic [HOLD_W-1:0] h);
        class_t c;
        c = CLS_NONE;
        if (h >= blocked_min)
            c = CLS_BLOCKED;
        if (h >= long_min && h < blocked_min)
            c = CLS_LONG;
        if (h >= short_min && h < long_min)
            c = CLS_SHORT;
        return c;
    endfunction

    function automatic void advance_tick(input logic level);
        class_t c;
        case (phase)
            PH_WAIT_PRESS:
            begin
                if (level)
                begin
                    settle = deb_ticks;
                    phase  = PH_SETTLE_PRESS;
                end
            end
            PH_SETTLE_PRESS:
            begin
                if (!level)
                    phase = PH_WAIT_PRESS;
                else if (settle != '0)
                    settle = settle - 1'b1;
                else
                begin
                    hold  = '0;
                    phase = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE:
            begin
                if (!level)
                begin
                    settle = deb_ticks;
                    phase  = PH_SETTLE_RELEASE;
                end
            end
            default:
            begin
                if (level)
                    phase = PH_WAIT_RELEASE;
                else if (settle != '0)
                    settle = settle - 1'b1;
                else
                begin
                    phase = PH_WAIT_PRESS;
                    if (last_cls == CLS_BLOCKED)
                        events_due.push_back(EV_RELEASED);
                end
            end
        endcase

        if (phase == PH_WAIT_RELEASE)
        begin
            if (hold != '1)
                hold = hold + 1'b1;
            c = grade_hold(hold);
            if (c != last_cls)
            begin
                last_cls = c;
                case (c)
                    CLS_SHORT:   events_due.push_back(EV_SHORT);
                    CLS_LONG:    events_due.push_back(EV_LONG);
                    CLS_BLOCKED: events_due.push_back(EV_BLOCKED);
                    default:     ;
                endcase
            end
        end
        else
            hold = '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_ticks   = DEBOUNCE_RESET;
            short_min   = SHORT_RESET;
            long_min    = LONG_RESET;
            blocked_min = BLOCKED_RESET;
            phase       = PH_WAIT_PRESS;
            settle      = '0;
            hold        = '0;
            last_cls    = CLS_NONE;
            events_due.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (events_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected event: got %0d, none expected", event_code);
                end
                else
                begin
                    want = events_due.pop_front();
                    if (event_code !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("event mismatch: expected %0d, got %0d", want, event_code);
                    end
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEBOUNCE: deb_ticks   = cfg_data[DEBOUNCE_W-1:0];
                    REG_SHORT:    short_min   = cfg_data[THRESH_W-1:0];
                    REG_LONG:     long_min    = cfg_data[THRESH_W-1:0];
                    REG_BLOCKED:  blocked_min = cfg_data[THRESH_W-1:0];
                    default:      ;
                endcase
            end

            if (in_valid && in_ready)
                advance_tick(pressed);

            pending = events_due.size();
        end
    end

endmodule

### sim/tb.sv
module tb;
    import bdpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BLOCK_ITEMS = 100;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  pressed    = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [1:0]            event_code;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    errors;
    int                    pending;

    bit steady     = 1'b1;
    bit hold_off   = 1'b0;
    int stall_left = 0;
    int cycles     = 0;
    int sent       = 0;
    int cur_deb    = DEBOUNCE_RESET;
    int cur_span   = 20;

    always #2 clk = ~clk;

    button_debounce_press_classifier_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pressed    (pressed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    press_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pressed    (pressed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                stall_left = 120;
                hold_off   = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_sample(input logic p);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        pressed  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic hold_level(input logic p, input int n);
        for (int i = 0; i < n; i++)
            push_sample(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_put(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // upper data bits of the debounce write are junk, must be masked
    task automatic write_config(input int deb, input int s, input int l, input int b);
        cfg_put(REG_DEBOUNCE, {6'($urandom), 10'(deb)});
        cfg_put(REG_SHORT, 16'(s));
        cfg_put(REG_LONG, 16'(l));
        cfg_put(REG_BLOCKED, 16'(b));
        cfg_write <= 1'b0;
        cur_deb = deb;
    endtask

    task automatic random_config();
        int d;
        int a;
        int b;
        int c;
        d = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
        begin
            a = $urandom_range(0, 25);
            b = $urandom_range(0, 25);
            c = $urandom_range(0, 25);
        end
        else
        begin
            a = $urandom_range(0, 12);
            b = a + $urandom_range(0, 10);
            c = b + $urandom_range(0, 10);
        end
        cur_span = ((a > b) ? ((a > c) ? a : c) : ((b > c) ? b : c)) + 6;
        write_config(d, a, b, c);
    endtask

    task automatic run_press(input int hold_len, input int bounces);
        hold_level(1'b1, hold_len);
        for (int k = 0; k < bounces; k++)
        begin
            hold_level(1'b0, $urandom_range(1, cur_deb + 1));
            hold_level(1'b1, $urandom_range(1, 4));
        end
        hold_level(1'b0, cur_deb + 2 + $urandom_range(0, 3));
    endtask

    task automatic random_block(input int n_items);
        int stop;
        stop = sent + n_items;
        while (sent < stop)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 10)) push_sample(1'($urandom_range(0, 1)));
            end
            else
                run_press(cur_deb + 1 + $urandom_range(0, cur_span), $urandom_range(0, 2));
        end
    endtask

    initial
    begin
        int blk;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset thresholds: bounce in press settle, then short
        hold_level(1'b0, 3);
        hold_level(1'b1, 5);
        hold_level(1'b0, 2);
        hold_level(1'b1, 42 + 110);
        hold_level(1'b0, 45);
        drain();

        // short, long, blocked, then released
        write_config(2, 3, 6, 10);
        hold_level(1'b1, 3 + 15);
        hold_level(1'b0, 6);
        drain();

        // bounce in release window drops class silently, short and long come again
        write_config(2, 5, 8, 30);
        hold_level(1'b1, 3 + 10);
        hold_level(1'b0, 2);
        hold_level(1'b1, 12);
        hold_level(1'b0, 6);
        drain();

        write_config(0, 0, 0, 0);
        run_press(6, 1);
        drain();

        write_config(20, 2, 5, 65535);
        hold_level(1'b1, 21 + 10);
        hold_level(1'b0, 25);
        drain();

        write_config(0, 10, 5, 20);
        run_press(30, 1);
        drain();

        steady = 1'b0;
        for (blk = 0; blk < 8; blk++)
        begin
            if (blk == 3)
            begin
                write_config(0, 1, 2, 3);
                hold_off = 1'b1;
            end
            else
                random_config();
            random_block(BLOCK_ITEMS);
            drain();
        end

        steady = 1'b1;
        random_config();
        random_block(BLOCK_ITEMS);
        drain();
        repeat (8) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
